### design/br1_pkg.sv
package br1_pkg;

  localparam int BYTE_W   = 8;
  localparam int LANE_MAX = 8;
  localparam int COUNT_W  = 4;
  localparam int LEN_W    = 8;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 72;

  // decode phase: what the next compressed byte means
  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_LITERAL = 2'd1,
    PH_REPEAT  = 2'd2
  } phase_t;

  // controller states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic load_job;   // take the accepted byte, set up its output job
    logic emit_word;  // build the next output word into the output register
  } br1_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic job_emits;  // the byte on the input makes at least one word
    logic word_last;  // the word being built now finishes the job
    logic out_free;   // output register can take a word this cycle
  } br1_status_t;

endpackage

### design/br1_ctrl.sv
module br1_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  br1_pkg::br1_status_t status,
  output br1_pkg::br1_cmd_t    cmd
);
  import br1_pkg::*;

  ctrl_state_t state;
  ctrl_state_t state_next;
  logic        accept;

  assign accept = in_valid && (state == ST_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && status.job_emits) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free && status.word_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    cmd.load_job  = 1'b0;
    cmd.emit_word = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.load_job = accept;
      end
      ST_EMIT: begin
        cmd.emit_word = status.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

### design/br1_datapath.sv
module br1_datapath #(
  parameter int LANES = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [br1_pkg::BYTE_W-1:0]  in_byte,
  input  logic                        in_final,
  input  br1_pkg::br1_cmd_t           cmd,
  output br1_pkg::br1_status_t        status,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [br1_pkg::BYTE_W-1:0]  out_bytes [br1_pkg::LANE_MAX],
  output logic [br1_pkg::COUNT_W-1:0] out_count,
  output logic                        out_run_end,
  output logic                        out_stream_end
);
  import br1_pkg::*;

  // lanes actually used, limited to the byte fields that exist
  localparam int LANE_N = (LANES < 1) ? 1 : ((LANES > LANE_MAX) ? LANE_MAX : LANES);
  localparam logic [LEN_W-1:0]   LANE_LEN = LEN_W'(LANE_N);
  localparam logic [COUNT_W-1:0] LANE_CNT = COUNT_W'(LANE_N);

  // decode state
  phase_t           phase, phase_next;
  logic [LEN_W-1:0] remaining, remaining_next;
  logic [LEN_W-1:0] rep_len, rep_len_next;

  // output job
  logic [LEN_W-1:0]  left;
  logic [BYTE_W-1:0] first_byte;
  logic [BYTE_W-1:0] fill_byte;
  logic              first_pend;
  logic              job_fin;

  logic [LEN_W-1:0]  job_total;
  logic [BYTE_W-1:0] job_first;
  logic [BYTE_W-1:0] job_fill;
  logic              job_fin_next;
  logic              job_emits;

  logic [LEN_W-1:0]   lit_rem;
  logic [LEN_W-1:0]   rep_eff;
  logic [COUNT_W-1:0] chunk;
  logic               word_last;
  logic [BYTE_W-1:0]  word_bytes [LANE_MAX];

  assign lit_rem = (remaining != '0) ? remaining : LEN_W'(1);
  assign rep_eff = (rep_len != '0) ? rep_len : LEN_W'(1);

  // decode the accepted byte into a job and the next phase
  always_comb begin
    phase_next     = phase;
    remaining_next = remaining;
    rep_len_next   = rep_len;
    job_total      = '0;
    job_first      = in_byte;
    job_fill       = in_byte;
    job_fin_next   = in_final;
    job_emits      = 1'b0;
    case (phase)
      PH_LITERAL: begin
        job_emits = 1'b1;
        if (in_final) begin
          job_total      = lit_rem;
          job_fill       = '0;
          phase_next     = PH_HEADER;
          remaining_next = '0;
        end else begin
          job_total      = LEN_W'(1);
          remaining_next = lit_rem - LEN_W'(1);
          if (lit_rem == LEN_W'(1)) phase_next = PH_HEADER;
        end
      end
      PH_REPEAT: begin
        job_emits    = 1'b1;
        job_total    = rep_eff;
        phase_next   = PH_HEADER;
        rep_len_next = '0;
      end
      default: begin
        phase_next = PH_HEADER;
        if (in_final) begin
          job_emits = 1'b1;
          job_total = '0;
          job_first = '0;
          job_fill  = '0;
        end else if (!in_byte[BYTE_W-1]) begin
          phase_next     = PH_LITERAL;
          remaining_next = in_byte + LEN_W'(1);
        end else begin
          phase_next   = PH_REPEAT;
          rep_len_next = LEN_W'(9'd257 - {1'b0, in_byte});
        end
      end
    endcase
  end

  // hold decode state, advance on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      remaining <= '0;
      rep_len   <= '0;
    end else if (cmd.load_job) begin
      phase     <= phase_next;
      remaining <= remaining_next;
      rep_len   <= rep_len_next;
    end
  end

  // word slicing: up to LANE_N bytes per word
  assign chunk     = (left > LANE_LEN) ? LANE_CNT : left[COUNT_W-1:0];
  assign word_last = (left <= LANE_LEN);

  always_comb begin
    for (int j = 0; j < LANE_MAX; j++) begin
      if (COUNT_W'(j) < chunk) begin
        word_bytes[j] = (j == 0 && first_pend) ? first_byte : fill_byte;
      end else begin
        word_bytes[j] = '0;
      end
    end
  end

  // job registers: load on accept, count down per word
  always_ff @(posedge clk) begin
    if (cmd.load_job) begin
      left       <= job_total;
      first_byte <= job_first;
      fill_byte  <= job_fill;
      job_fin    <= job_fin_next;
      first_pend <= 1'b1;
    end else if (cmd.emit_word) begin
      left       <= left - LEN_W'(chunk);
      first_pend <= 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_word) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_word) begin
      out_bytes      <= word_bytes;
      out_count      <= chunk;
      out_run_end    <= word_last;
      out_stream_end <= word_last && job_fin;
    end
  end

  assign status.job_emits = job_emits;
  assign status.word_last = word_last;
  assign status.out_free  = !out_valid || out_ready;

endmodule

### design/byterun1_decoder.sv
// Byte-run (PackBits-like) decoder. Compressed bytes enter one per request on the
// s_ side, the last one flagged by s_tlast; decoded bytes leave as words of up
// to LANES bytes (1..8) on the m_ side, m_tlast marking the last word caused by
// one input byte and m_tuser the end of the decoded stream. A header byte that
// is not final makes no word; a data byte or a final header is accepted and then
// makes its output words (a final header makes one empty word), so a literal
// byte that is not final makes one word and a repeat of L bytes makes
// ceil(L/LANES) words. The word sequencer builds one word per cycle into the
// output register while that register is free, and a stalled m_tready holds
// it; no new byte is taken until the last word of a job is built, and the next
// byte is taken while that last word waits.
module byterun1_decoder #(
  parameter int LANES = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [br1_pkg::IN_TDATA_W-1:0]     s_tdata,  // [7:0] packed_byte
  input  logic                               s_tlast,  // final_byte
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // [7:0] out_byte0 ... [63:56] out_byte7, [67:64] byte_count, [71:68] zero
  output logic [br1_pkg::OUT_TDATA_W-1:0]    m_tdata,
  output logic                               m_tlast,  // run_end
  output logic                               m_tuser   // stream_end
);
  import br1_pkg::*;

  br1_cmd_t           cmd;
  br1_status_t        status;
  logic [BYTE_W-1:0]  out_bytes [LANE_MAX];
  logic [COUNT_W-1:0] out_count;

  br1_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  br1_datapath #(
    .LANES (LANES)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .in_byte        (s_tdata[BYTE_W-1:0]),
    .in_final       (s_tlast),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .out_bytes      (out_bytes),
    .out_count      (out_count),
    .out_run_end    (m_tlast),
    .out_stream_end (m_tuser)
  );

  // pack the output word, lane 0 lowest
  always_comb begin
    m_tdata = '0;
    for (int j = 0; j < LANE_MAX; j++) begin
      m_tdata[j*BYTE_W +: BYTE_W] = out_bytes[j];
    end
    m_tdata[LANE_MAX*BYTE_W +: COUNT_W] = out_count;
  end

endmodule

### test/byterun1_decoder_tb.sv
module byterun1_decoder_tb;
  import br1_pkg::*;

  localparam int LANE_COUNT = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 40;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_TDATA_W-1:0] s_tdata;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic m_tuser;

  // one decoded output word as the block should present it
  typedef struct packed {
    logic [LANE_COUNT-1:0][BYTE_W-1:0] lanes;
    logic [COUNT_W-1:0] count;
    logic run_end;
    logic stream_end;
  } decoded_word_t;

  // tracks the decode state and the words still owed by the block
  class byterun_scoreboard;
    phase_t phase;
    logic [LEN_W-1:0] literal_left;
    logic [LEN_W-1:0] repeat_len;
    decoded_word_t words_due[$];
    int errors;

    function new();
      phase = PH_HEADER;
      literal_left = '0;
      repeat_len = '0;
      errors = 0;
    endfunction

    // split a run of total bytes (first, then fill) into words
    function void queue_decoded_run(int unsigned total, logic [7:0] first,
                                    logic [7:0] fill, bit fin);
      decoded_word_t w;
      int unsigned done;
      int unsigned chunk;
      if (total == 0) begin
        w = '0;
        w.run_end = 1'b1;
        w.stream_end = fin;
        words_due.push_back(w);
        return;
      end
      done = 0;
      while (done < total) begin
        chunk = total - done;
        if (chunk > LANE_COUNT) chunk = LANE_COUNT;
        w = '0;
        for (int j = 0; j < chunk; j++)
          w.lanes[j] = (done + j == 0) ? first : fill;
        done += chunk;
        w.count = chunk[COUNT_W-1:0];
        w.run_end = (done >= total);
        w.stream_end = (done >= total) && fin;
        words_due.push_back(w);
      end
    endfunction

    // advance the decode state on one accepted compressed byte
    function void note_request(logic [7:0] b, bit fin);
      int unsigned rem;
      case (phase)
        PH_LITERAL: begin
          rem = (literal_left == 0) ? 1 : literal_left;
          if (fin) begin
            // a literal run cut short is padded with zeros
            queue_decoded_run(rem, b, 8'h00, 1'b1);
            phase = PH_HEADER;
            literal_left = '0;
          end else begin
            queue_decoded_run(1, b, b, 1'b0);
            rem--;
            literal_left = rem[LEN_W-1:0];
            if (rem == 0) phase = PH_HEADER;
          end
        end
        PH_REPEAT: begin
          rem = (repeat_len == 0) ? 1 : repeat_len;
          queue_decoded_run(rem, b, b, fin);
          phase = PH_HEADER;
          repeat_len = '0;
        end
        default: begin
          phase = PH_HEADER;
          if (fin) begin
            // a final header yields one empty word marked stream end
            queue_decoded_run(0, 8'h00, 8'h00, 1'b1);
          end else if (b < 8'd128) begin
            phase = PH_LITERAL;
            literal_left = b + 8'd1;
          end else begin
            phase = PH_REPEAT;
            repeat_len = 8'(9'd257 - {1'b0, b});
          end
        end
      endcase
    endfunction

    // compare one accepted output word with the oldest one owed
    function void check_word(logic [OUT_TDATA_W-1:0] data, logic last, logic user);
      decoded_word_t w;
      if (words_due.size() == 0) begin
        $error("unexpected word: tdata %0h tlast %0b tuser %0b", data, last, user);
        errors++;
        return;
      end
      w = words_due.pop_front();
      for (int i = 0; i < LANE_COUNT; i++) begin
        if (data[BYTE_W*i +: BYTE_W] !== w.lanes[i]) begin
          $error("out_byte%0d: expected %0h, actual %0h", i, w.lanes[i],
                 data[BYTE_W*i +: BYTE_W]);
          errors++;
        end
      end
      if (data[67:64] !== w.count) begin
        $error("byte_count: expected %0d, actual %0d", w.count, data[67:64]);
        errors++;
      end
      if (last !== w.run_end) begin
        $error("run_end: expected %0b, actual %0b", w.run_end, last);
        errors++;
      end
      if (user !== w.stream_end) begin
        $error("stream_end: expected %0b, actual %0b", w.stream_end, user);
        errors++;
      end
    endfunction
  endclass

  byterun_scoreboard sb = new();

  bit idling_on = 1'b1;
  bit hold_request = 1'b0;
  int sent_count = 0;

  byterun1_decoder #(
    .LANES(LANE_COUNT)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tlast(m_tlast),
    .m_tuser(m_tuser)
  );

  always #5 clk = ~clk;

  // offer one compressed byte and hold it until the request is taken
  task automatic send_request(input logic [7:0] b, input bit fin);
    @(negedge clk);
    while (idling_on && $urandom_range(0, 99) < 21) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= fin;
    do @(posedge clk); while (!s_tready);
    sb.note_request(b, fin);
    sent_count++;
  endtask

  task automatic wait_for_drain();
    while (sb.words_due.size() != 0) @(posedge clk);
  endtask

  // mostly well-formed streams with random content, some noise mixed in
  task automatic send_random_stream();
    int runs;
    int len;
    int cut;
    int unsigned pick;
    bit last_run;
    runs = $urandom_range(1, 6);
    for (int r = 0; r < runs; r++) begin
      last_run = (r == runs - 1);
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        send_request(8'($urandom), $urandom_range(0, 7) == 0);
      end else if (pick < 14 && last_run) begin
        send_request(8'($urandom), 1'b1);
      end else if (pick < 55) begin
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        cut = (last_run && $urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1)
                                                      : len - 1;
        send_request(8'(len - 1), 1'b0);
        for (int i = 0; i <= cut; i++)
          send_request(8'($urandom), last_run && i == cut);
      end else begin
        if ($urandom_range(0, 1) == 0)
          send_request(8'($urandom_range(248, 255)), 1'b0);
        else
          send_request(8'($urandom_range(128, 255)), 1'b0);
        send_request(8'($urandom), last_run);
      end
    end
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 99) < 21) begin
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // check every accepted output word
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_word(m_tdata, m_tlast, m_tuser);
  end

  initial begin
    bit hold_done;
    bit pause_done;
    hold_done = 1'b0;
    pause_done = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // final header alone
    send_request(8'h00, 1'b1);
    // one-byte literal
    send_request(8'h00, 1'b0);
    send_request(8'hFF, 1'b0);
    // longest repeat, 129 bytes
    send_request(8'h80, 1'b0);
    send_request(8'hA5, 1'b0);
    // shortest repeat
    send_request(8'hFF, 1'b0);
    send_request(8'h00, 1'b0);
    // repeats that fill exactly one word and spill one byte over
    send_request(8'hF9, 1'b0);
    send_request(8'h3C, 1'b0);
    send_request(8'hF8, 1'b0);
    send_request(8'h96, 1'b0);
    // literal run ending on the final byte
    send_request(8'h02, 1'b0);
    send_request(8'h11, 1'b0);
    send_request(8'h22, 1'b0);
    send_request(8'h33, 1'b1);
    // repeat that ends the stream
    send_request(8'h81, 1'b0);
    send_request(8'hC3, 1'b1);
    // longest literal run cut short at once by the final flag
    send_request(8'h7F, 1'b0);
    send_request(8'h5A, 1'b1);

    while (sent_count < 270) begin
      idling_on = !(sent_count >= 130 && sent_count < 210);
      if (!hold_done && sent_count >= 60) begin
        hold_done = 1'b1;
        hold_request = 1'b1;
      end
      if (!pause_done && sent_count >= 230) begin
        pause_done = 1'b1;
        @(negedge clk);
        s_tvalid <= 1'b0;
        wait_for_drain();
      end
      send_random_stream();
    end
    idling_on = 1'b1;
    @(negedge clk);
    s_tvalid <= 1'b0;
    wait_for_drain();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // run limit
  initial begin
    #3000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
